>>> rtl/dosc_pkg.sv
// types and constants shared by the door opener state controller
// no dependencies; compile first

package dosc_pkg;

   typedef enum logic [2:0] {
      DOOR_OPEN          = 3'd0,
      DOOR_CLOSED        = 3'd1,
      DOOR_OPENING       = 3'd2,
      DOOR_CLOSING       = 3'd3,
      DOOR_STOP_OPENING  = 3'd4,
      DOOR_STOP_CLOSING  = 3'd5,
      DOOR_UNKNOWN       = 3'd6
   } door_state_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_DOOR  = 2'd1,
      OP_LIGHT = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic [1:0] LINE_NONE   = 2'd0;
   localparam logic [1:0] LINE_OPEN   = 2'd1;
   localparam logic [1:0] LINE_CLOSE  = 2'd2;
   localparam logic [1:0] LINE_SHARED = 2'd3;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;
   localparam logic [CsrIndexWidth-1:0] CSR_SINGLE_BUTTON = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SETTLE        = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_TRAVEL    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_AUTO_CLOSE    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_EVAL_PERIOD   = 3'd4;

   localparam logic [31:0] SETTLE_RESET      = 32'd5000;
   localparam logic [31:0] MAX_TRAVEL_RESET  = 32'd30000;
   localparam logic [15:0] EVAL_PERIOD_RESET = 16'd500;

   typedef struct packed {
      logic        single_button;
      logic [31:0] settle_ms;
      logic [31:0] max_travel_ms;
      logic [31:0] auto_close_ms;
      logic [15:0] eval_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic       open_sensor_level;
      logic       closed_sensor_level;
      logic       light_switch_level;
      logic       command_value;
   } item_type;

   typedef struct packed {
      logic [31:0]    now_ms;
      logic [31:0]    last_eval_ms;
      logic [31:0]    operated_at_ms;
      logic [31:0]    open_since_ms;
      door_state_type cur_state;
      door_state_type last_known_state;
      logic [2:0]     sensor_flags;
      logic           remote_light;
      logic           light_level;
      logic           eval_valid;
      logic           operated_valid;
      logic           open_valid;
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0] door_state;
      logic [1:0] pulse_line;
      logic [1:0] pulse_count;
      logic       light_on;
      logic       open_sensed;
      logic       closed_sensed;
      logic       light_switch_on;
      logic       light_requested;
   } result_type;

endpackage

>>> rtl/dosc_if.sv
// valid/ready channel interfaces for request and response transactions
// no package dependencies

interface dosc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic       open_sensor_level;
   logic       closed_sensor_level;
   logic       light_switch_level;
   logic       command_value;

   modport source (output valid, op, open_sensor_level, closed_sensor_level,
                   light_switch_level, command_value, input ready);
   modport sink (input valid, op, open_sensor_level, closed_sensor_level,
                 light_switch_level, command_value, output ready);
endinterface

interface dosc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] door_state;
   logic [1:0] pulse_line;
   logic [1:0] pulse_count;
   logic       light_on;
   logic       open_sensed;
   logic       closed_sensed;
   logic       light_switch_on;
   logic       light_requested;

   modport source (output valid, door_state, pulse_line, pulse_count, light_on,
                   open_sensed, closed_sensed, light_switch_on, light_requested,
                   input ready);
   modport sink (input valid, door_state, pulse_line, pulse_count, light_on,
                 open_sensed, closed_sensed, light_switch_on, light_requested,
                 output ready);
endinterface

>>> rtl/dosc_csr.sv
// configuration registers of the door opener state controller
// depends on dosc_pkg

module dosc_csr
   import dosc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.single_button  <= 1'b0;
         cfg_ff.settle_ms      <= SETTLE_RESET;
         cfg_ff.max_travel_ms  <= MAX_TRAVEL_RESET;
         cfg_ff.auto_close_ms  <= 32'd0;
         cfg_ff.eval_period_ms <= EVAL_PERIOD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SINGLE_BUTTON: cfg_ff.single_button  <= csr_wr_data[0];
            CSR_SETTLE:        cfg_ff.settle_ms      <= csr_wr_data;
            CSR_MAX_TRAVEL:    cfg_ff.max_travel_ms  <= csr_wr_data;
            CSR_AUTO_CLOSE:    cfg_ff.auto_close_ms  <= csr_wr_data;
            CSR_EVAL_PERIOD:   cfg_ff.eval_period_ms <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/dosc_step.sv
// next-state and result logic for one transaction
// depends on dosc_pkg

module dosc_step
   import dosc_pkg::*;
(
   input  cfg_type        cfg,
   input  item_type       item,
   input  ctrl_state_type cur,
   output ctrl_state_type nxt,
   output result_type     res
);

   // pulses for a door command; count 0 means no pulse
   function automatic logic [1:0] pulse_count_of(input logic single,
                                                 input logic open_cmd,
                                                 input door_state_type s);
      logic [1:0] cnt;
      cnt = 2'd0;
      if (!single) begin
         cnt = 2'd1;
      end else if (open_cmd) begin
         if (s == DOOR_CLOSED || s == DOOR_STOP_CLOSING || s == DOOR_UNKNOWN) cnt = 2'd1;
         else if (s == DOOR_CLOSING) cnt = 2'd2;
         else if (s == DOOR_STOP_OPENING) cnt = 2'd3;
      end else begin
         if (s == DOOR_OPEN || s == DOOR_STOP_OPENING || s == DOOR_UNKNOWN) cnt = 2'd1;
         else if (s == DOOR_OPENING) cnt = 2'd2;
         else if (s == DOOR_STOP_CLOSING) cnt = 2'd3;
      end
      return cnt;
   endfunction

   function automatic logic [1:0] pulse_line_of(input logic single, input logic open_cmd,
                                                input logic [1:0] cnt);
      logic [1:0] line;
      if (!single) line = open_cmd ? LINE_OPEN : LINE_CLOSE;
      else line = (cnt != 2'd0) ? LINE_SHARED : LINE_NONE;
      return line;
   endfunction

   logic [31:0]    now_inc;
   logic           do_eval;
   logic           so, sc, sw;
   logic           settled;
   logic           travel_out;
   logic           auto_due;
   logic           op_fresh;
   door_state_type s;
   logic [1:0]     cnt;
   logic [1:0]     line;

   always_comb begin
      now_inc    = cur.now_ms + 32'd1;
      do_eval    = !cur.eval_valid || ((now_inc - cur.last_eval_ms) > {16'd0, cfg.eval_period_ms});
      so         = !item.open_sensor_level;
      sc         = !item.closed_sensor_level;
      sw         = !item.light_switch_level;
      settled    = !cur.operated_valid || ((now_inc - cur.operated_at_ms) >= cfg.settle_ms);
      auto_due   = (cfg.auto_close_ms != 32'd0) &&
                   ((now_inc - cur.open_since_ms) >= cfg.auto_close_ms);
      op_fresh   = 1'b0;
      travel_out = 1'b0;
      s          = cur.cur_state;
      cnt        = 2'd0;
      line       = LINE_NONE;
      nxt        = cur;

      case (op_type'(item.op))
         OP_TICK: begin
            nxt.now_ms = now_inc;
            if (do_eval) begin
               nxt.last_eval_ms = now_inc;
               nxt.eval_valid   = 1'b1;
               if (settled) begin
                  if (so && !sc) s = DOOR_OPEN;
                  else if (!so && sc) s = DOOR_CLOSED;
                  else if (so && sc) s = DOOR_UNKNOWN;
                  else if (s != DOOR_OPENING && s != DOOR_CLOSING &&
                           s != DOOR_STOP_OPENING && s != DOOR_STOP_CLOSING) begin
                     // both sensors clear: door left its last known end
                     if (cur.last_known_state == DOOR_CLOSED) s = DOOR_OPENING;
                     else if (cur.last_known_state == DOOR_OPEN) s = DOOR_CLOSING;
                     else s = DOOR_UNKNOWN;
                     if (s == DOOR_OPENING || s == DOOR_CLOSING) begin
                        op_fresh             = 1'b1;
                        nxt.operated_at_ms   = now_inc;
                        nxt.operated_valid   = 1'b1;
                     end
                  end
               end
               nxt.cur_state = s;
               if (s != DOOR_OPEN) nxt.open_valid = 1'b0;
               // a freshly taken operation time has zero elapsed
               travel_out = op_fresh ? (cfg.max_travel_ms == 32'd0)
                                     : (!cur.operated_valid ||
                                        ((now_inc - cur.operated_at_ms) >= cfg.max_travel_ms));
               if (s == DOOR_OPEN || s == DOOR_CLOSED) begin
                  nxt.operated_valid   = 1'b0;
                  nxt.last_known_state = s;
                  if (s == DOOR_OPEN) begin
                     if (!cur.open_valid) begin
                        nxt.open_since_ms = now_inc;
                        nxt.open_valid    = 1'b1;
                     end else if (auto_due) begin
                        cnt                = pulse_count_of(cfg.single_button, 1'b0, DOOR_OPEN);
                        line               = pulse_line_of(cfg.single_button, 1'b0, cnt);
                        nxt.cur_state      = DOOR_CLOSING;
                        nxt.operated_at_ms = now_inc;
                        nxt.operated_valid = 1'b1;
                     end
                  end
               end else if (s == DOOR_OPENING || s == DOOR_CLOSING) begin
                  if (travel_out) begin
                     nxt.operated_valid = 1'b0;
                     nxt.cur_state = (s == DOOR_OPENING) ? DOOR_STOP_OPENING
                                                         : DOOR_STOP_CLOSING;
                  end
               end
               nxt.sensor_flags = {sw, sc, so};
               nxt.light_level  = sw || cur.remote_light;
            end
         end
         OP_DOOR: begin
            cnt           = pulse_count_of(cfg.single_button, item.command_value, cur.cur_state);
            line          = pulse_line_of(cfg.single_button, item.command_value, cnt);
            nxt.cur_state = item.command_value ? DOOR_OPENING : DOOR_CLOSING;
            if (cnt != 2'd0) begin
               nxt.operated_at_ms = cur.now_ms;
               nxt.operated_valid = 1'b1;
            end
         end
         OP_LIGHT: begin
            nxt.remote_light = item.command_value;
            nxt.light_level  = cur.sensor_flags[2] | item.command_value;
         end
         default: ;
      endcase

      res.door_state      = nxt.cur_state;
      res.pulse_line      = line;
      res.pulse_count     = cnt;
      res.light_on        = nxt.light_level;
      res.open_sensed     = nxt.sensor_flags[0];
      res.closed_sensed   = nxt.sensor_flags[1];
      res.light_switch_on = nxt.sensor_flags[2];
      res.light_requested = nxt.remote_light;
   end

endmodule

>>> rtl/door_opener_state_controller.sv
// Door opener state controller, top level.
// Depends on dosc_pkg, dosc_if, dosc_csr and dosc_step.
//
// Request channel (req_chan): one transaction per item: a millisecond tick,
// a door command, a light command or a no-op, with the debounced sensor and
// switch levels (active low) and the command value.
// Response channel (rsp_chan): one transaction per request with the door
// state, the button pulse request made by that request, the light drive and
// the sensor flags of the last evaluation.
// Configuration: csr_wr_en/csr_index/csr_wr_data write one register per
// cycle; write only while no transaction is in flight.
// A request is taken into an input register, processed in one pass of
// logic and written into the response register once that register is free
// or being read. Throughput is one transaction per cycle while the receiver
// is ready, set by that single pass over the controller state register.
// Reset clears the state to unknown door, all times to zero and the
// registers to their defaults; no transaction is pending after reset.
// When the receiver stalls, the response register holds and the input
// register takes one more request; further requests wait on req_chan.ready.

module door_opener_state_controller
   import dosc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wr_data,
   dosc_req_if.sink                 req_chan,
   dosc_rsp_if.source               rsp_chan
);

   cfg_type        cfg;
   item_type       item_ff;
   logic           in_valid_ff;
   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   result_type     res_in;
   result_type     rsp_data_ff;
   logic           rsp_valid_ff;
   logic           advance;
   logic           req_take;

   dosc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   dosc_step u_step (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.op                  <= req_chan.op;
         item_ff.open_sensor_level   <= req_chan.open_sensor_level;
         item_ff.closed_sensor_level <= req_chan.closed_sensor_level;
         item_ff.light_switch_level  <= req_chan.light_switch_level;
         item_ff.command_value       <= req_chan.command_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.now_ms           <= 32'd0;
         state_ff.last_eval_ms     <= 32'd0;
         state_ff.operated_at_ms   <= 32'd0;
         state_ff.open_since_ms    <= 32'd0;
         state_ff.cur_state        <= DOOR_UNKNOWN;
         state_ff.last_known_state <= DOOR_UNKNOWN;
         state_ff.sensor_flags     <= 3'd0;
         state_ff.remote_light     <= 1'b0;
         state_ff.light_level      <= 1'b0;
         state_ff.eval_valid       <= 1'b0;
         state_ff.operated_valid   <= 1'b0;
         state_ff.open_valid       <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= res_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.door_state      = rsp_data_ff.door_state;
   assign rsp_chan.pulse_line      = rsp_data_ff.pulse_line;
   assign rsp_chan.pulse_count     = rsp_data_ff.pulse_count;
   assign rsp_chan.light_on        = rsp_data_ff.light_on;
   assign rsp_chan.open_sensed     = rsp_data_ff.open_sensed;
   assign rsp_chan.closed_sensed   = rsp_data_ff.closed_sensed;
   assign rsp_chan.light_switch_on = rsp_data_ff.light_switch_on;
   assign rsp_chan.light_requested = rsp_data_ff.light_requested;

endmodule

>>> test/door_opener_state_controller_tb.sv
// Testbench for door_opener_state_controller: directed table, then random phases
// under several register settings and idle patterns, checked against a predictor.
// Depends on dosc_pkg, dosc_if and the controller RTL.
`timescale 1ns / 100ps

module door_opener_state_controller_tb;
   import dosc_pkg::*;

   localparam int POS_CLOSED = 0;
   localparam int POS_MID    = 1;
   localparam int POS_OPEN   = 2;
   localparam int RANDOM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 155;

   typedef struct {
      bit         is_cfg;
      cfg_type    cfg;
      item_type   stim;
      bit         typed;
      result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                     csr_wr_en;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wr_data;

   dosc_req_if req_chan ();
   dosc_rsp_if rsp_chan ();

   door_opener_state_controller dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the controller registers and state
   logic           btn_shared;
   logic [31:0]    settle_time, travel_limit, auto_close_time;
   logic [15:0]    eval_interval;
   logic [31:0]    ms_count, eval_stamp, op_stamp, open_stamp;
   door_state_type door_st, known_st;
   logic [2:0]     sensed;
   logic           remote_req, lamp;
   logic           eval_seen, op_armed, open_armed;
   logic [1:0]     pulse_line_now, pulse_count_now;

   result_type   expected_results[$];
   plan_row_type door_plan[$];
   int           mismatch_count = 0;
   int           send_gap_pct, rsp_stall_pct;
   int           hold_requests = 0, hold_served = 0, hold_left = 0;
   int           items_sent = 0, pulse_items = 0, settings_used = 0;

   // physical door seen by the random stimulus
   int   phys_pos = POS_CLOSED, travel_left = 0, travel_to = POS_CLOSED;
   logic switch_lvl = 1'b1;

   task automatic reset_model();
      btn_shared = 1'b0;
      settle_time = SETTLE_RESET;
      travel_limit = MAX_TRAVEL_RESET;
      auto_close_time = '0;
      eval_interval = EVAL_PERIOD_RESET;
      ms_count = '0;
      eval_stamp = '0;
      op_stamp = '0;
      open_stamp = '0;
      door_st = DOOR_UNKNOWN;
      known_st = DOOR_UNKNOWN;
      sensed = '0;
      remote_req = 1'b0;
      lamp = 1'b0;
      eval_seen = 1'b0;
      op_armed = 1'b0;
      open_armed = 1'b0;
   endtask

   function automatic logic [31:0] elapsed_since(logic [31:0] stamp);
      return ms_count - stamp;
   endfunction

   function automatic void issue_door_command(logic open_cmd);
      logic [1:0] n;
      n = 2'd0;
      if (!btn_shared) begin
         pulse_line_now = open_cmd ? LINE_OPEN : LINE_CLOSE;
         n = 2'd1;
      end else begin
         if (open_cmd) begin
            case (door_st)
               DOOR_CLOSED, DOOR_STOP_CLOSING, DOOR_UNKNOWN: n = 2'd1;
               DOOR_CLOSING: n = 2'd2;
               DOOR_STOP_OPENING: n = 2'd3;
               default: n = 2'd0;
            endcase
         end else begin
            case (door_st)
               DOOR_OPEN, DOOR_STOP_OPENING, DOOR_UNKNOWN: n = 2'd1;
               DOOR_OPENING: n = 2'd2;
               DOOR_STOP_CLOSING: n = 2'd3;
               default: n = 2'd0;
            endcase
         end
         pulse_line_now = (n != 2'd0) ? LINE_SHARED : LINE_NONE;
      end
      door_st = open_cmd ? DOOR_OPENING : DOOR_CLOSING;
      if (n != 2'd0) begin
         op_stamp = ms_count;
         op_armed = 1'b1;
      end
      pulse_count_now = n;
   endfunction

   function automatic void evaluate_sensors(logic open_lvl, logic closed_lvl, logic sw_lvl);
      logic           so, sc, sw;
      door_state_type s;
      so = !open_lvl;
      sc = !closed_lvl;
      sw = !sw_lvl;
      s = door_st;
      eval_stamp = ms_count;
      eval_seen = 1'b1;
      if (!op_armed || elapsed_since(op_stamp) >= settle_time) begin
         if (so && !sc) s = DOOR_OPEN;
         else if (!so && sc) s = DOOR_CLOSED;
         else if (so && sc) s = DOOR_UNKNOWN;
         else if (!(s inside {DOOR_OPENING, DOOR_CLOSING, DOOR_STOP_OPENING,
                              DOOR_STOP_CLOSING})) begin
            // door left a limit on its own: assume it travels away from it
            if (known_st == DOOR_CLOSED) s = DOOR_OPENING;
            else if (known_st == DOOR_OPEN) s = DOOR_CLOSING;
            else s = DOOR_UNKNOWN;
            if (s == DOOR_OPENING || s == DOOR_CLOSING) begin
               op_stamp = ms_count;
               op_armed = 1'b1;
            end
         end
      end
      door_st = s;
      if (s != DOOR_OPEN) open_armed = 1'b0;
      if (s == DOOR_OPEN || s == DOOR_CLOSED) begin
         op_armed = 1'b0;
         known_st = s;
         if (s == DOOR_OPEN) begin
            if (!open_armed) begin
               open_stamp = ms_count;
               open_armed = 1'b1;
            end else if (auto_close_time != 0 &&
                         elapsed_since(open_stamp) >= auto_close_time) begin
               issue_door_command(1'b0);
            end
         end
      end else if (s == DOOR_OPENING || s == DOOR_CLOSING) begin
         if (!op_armed || elapsed_since(op_stamp) >= travel_limit) begin
            op_armed = 1'b0;
            door_st = (s == DOOR_OPENING) ? DOOR_STOP_OPENING : DOOR_STOP_CLOSING;
         end
      end
      sensed = {sw, sc, so};
      lamp = sw || remote_req;
   endfunction

   function automatic result_type predict_door_result(item_type it);
      result_type r;
      pulse_line_now = LINE_NONE;
      pulse_count_now = 2'd0;
      case (it.op)
         OP_TICK: begin
            ms_count = ms_count + 32'd1;
            if (!eval_seen || elapsed_since(eval_stamp) > eval_interval)
               evaluate_sensors(it.open_sensor_level, it.closed_sensor_level,
                                it.light_switch_level);
         end
         OP_DOOR: issue_door_command(it.command_value);
         OP_LIGHT: begin
            remote_req = it.command_value;
            lamp = sensed[2] | remote_req;
         end
         default: ;
      endcase
      r.door_state = door_st;
      r.pulse_line = pulse_line_now;
      r.pulse_count = pulse_count_now;
      r.light_on = lamp;
      r.open_sensed = sensed[0];
      r.closed_sensed = sensed[1];
      r.light_switch_on = sensed[2];
      r.light_requested = remote_req;
      return r;
   endfunction

   function automatic item_type make_item(op_type op, logic o, logic c, logic s, logic v);
      item_type it;
      it.op = op;
      it.open_sensor_level = o;
      it.closed_sensor_level = c;
      it.light_switch_level = s;
      it.command_value = v;
      return it;
   endfunction

   function automatic cfg_type make_cfg(logic sb, logic [31:0] settle, logic [31:0] travel,
                                        logic [31:0] auto_close, logic [15:0] period);
      cfg_type c;
      c.single_button = sb;
      c.settle_ms = settle;
      c.max_travel_ms = travel;
      c.auto_close_ms = auto_close;
      c.eval_period_ms = period;
      return c;
   endfunction

   function automatic plan_row_type item_row(op_type op, logic o, logic c, logic s, logic v);
      plan_row_type row;
      row.is_cfg = 1'b0;
      row.cfg = '0;
      row.stim = make_item(op, o, c, s, v);
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic plan_row_type typed_row(op_type op, logic o, logic c, logic s, logic v,
                                              door_state_type st, logic [1:0] line,
                                              logic [1:0] cnt, logic lt, logic os, logic cs,
                                              logic ss, logic rq);
      plan_row_type row;
      row = item_row(op, o, c, s, v);
      row.typed = 1'b1;
      row.want = '{door_state: st, pulse_line: line, pulse_count: cnt, light_on: lt,
                   open_sensed: os, closed_sensed: cs, light_switch_on: ss,
                   light_requested: rq};
      return row;
   endfunction

   function automatic plan_row_type cfg_row(cfg_type c);
      plan_row_type row;
      row.is_cfg = 1'b1;
      row.cfg = c;
      row.stim = '0;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   // random transaction, mostly consistent with a door that actually moves
   function automatic item_type next_random_item();
      item_type it;
      int       pick;
      it = make_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (pick < 76) begin
         if (travel_left != 0) begin
            travel_left--;
            if (travel_left == 0) phys_pos = travel_to;
         end
         if ($urandom_range(19) == 0) switch_lvl = ~switch_lvl;
         if ($urandom_range(99) >= 8) begin
            it.open_sensor_level = (phys_pos != POS_OPEN);
            it.closed_sensor_level = (phys_pos != POS_CLOSED);
            it.light_switch_level = switch_lvl;
         end
      end else if (pick < 89) begin
         it.op = OP_DOOR;
         travel_to = it.command_value ? POS_OPEN : POS_CLOSED;
         if (travel_to != phys_pos || travel_left != 0) begin
            phys_pos = POS_MID;
            travel_left = $urandom_range(12, 1);
         end
      end else if (pick < 97) begin
         it.op = OP_LIGHT;
      end else begin
         it.op = OP_NONE;
      end
      return it;
   endfunction

   task automatic check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // response side: compare, then decide ready for the next cycle
   always @(posedge clock) begin
      result_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("response transaction with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("door_state", want.door_state, rsp_chan.door_state);
            check_field("pulse_line", want.pulse_line, rsp_chan.pulse_line);
            check_field("pulse_count", want.pulse_count, rsp_chan.pulse_count);
            check_field("light_on", want.light_on, rsp_chan.light_on);
            check_field("open_sensed", want.open_sensed, rsp_chan.open_sensed);
            check_field("closed_sensed", want.closed_sensed, rsp_chan.closed_sensed);
            check_field("light_switch_on", want.light_switch_on, rsp_chan.light_switch_on);
            check_field("light_requested", want.light_requested, rsp_chan.light_requested);
         end
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = 80;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_item(item_type it);
      while ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op <= it.op;
      req_chan.open_sensor_level <= it.open_sensor_level;
      req_chan.closed_sensor_level <= it.closed_sensor_level;
      req_chan.light_switch_level <= it.light_switch_level;
      req_chan.command_value <= it.command_value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // two-stage pipe, plus margin
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic program_regs(cfg_type c);
      wait_idle();
      csr_write(CSR_SINGLE_BUTTON, {31'd0, c.single_button});
      csr_write(CSR_SETTLE, c.settle_ms);
      csr_write(CSR_MAX_TRAVEL, c.max_travel_ms);
      csr_write(CSR_AUTO_CLOSE, c.auto_close_ms);
      csr_write(CSR_EVAL_PERIOD, {16'd0, c.eval_period_ms});
      csr_wr_en <= 1'b0;
      btn_shared = c.single_button;
      settle_time = c.settle_ms;
      travel_limit = c.max_travel_ms;
      auto_close_time = c.auto_close_ms;
      eval_interval = c.eval_period_ms;
      settings_used++;
   endtask

   task automatic send_and_predict(item_type it, bit typed, result_type typed_want);
      result_type r;
      send_item(it);
      r = predict_door_result(it);
      if (r.pulse_count != 2'd0) pulse_items++;
      expected_results.push_back(typed ? typed_want : r);
   endtask

   initial begin
      #1_000_000;
      $display("door_opener_state_controller_tb NOT OK");
      $finish;
   end

   initial begin
      cfg_type c;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_SINGLE_BUTTON;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.op = OP_TICK;
      req_chan.open_sensor_level = 1'b1;
      req_chan.closed_sensor_level = 1'b1;
      req_chan.light_switch_level = 1'b1;
      req_chan.command_value = 1'b0;
      rsp_chan.ready = 1'b0;
      reset_model();
      send_gap_pct = 20;
      rsp_stall_pct = 48;

      // defaults after reset: separate lines, 500 ms evaluation period
      door_plan.push_back(typed_row(OP_TICK, 0, 1, 1, 0,
                                    DOOR_OPEN, LINE_NONE, 0, 0, 1, 0, 0, 0));
      door_plan.push_back(typed_row(OP_NONE, 1, 1, 1, 1,
                                    DOOR_OPEN, LINE_NONE, 0, 0, 1, 0, 0, 0));
      door_plan.push_back(typed_row(OP_LIGHT, 1, 0, 0, 1,
                                    DOOR_OPEN, LINE_NONE, 0, 1, 1, 0, 0, 1));
      door_plan.push_back(typed_row(OP_DOOR, 0, 0, 0, 0,
                                    DOOR_CLOSING, LINE_CLOSE, 1, 1, 1, 0, 0, 1));
      door_plan.push_back(typed_row(OP_DOOR, 1, 1, 1, 1,
                                    DOOR_OPENING, LINE_OPEN, 1, 1, 1, 0, 0, 1));
      door_plan.push_back(item_row(OP_TICK, 0, 0, 0, 1));
      door_plan.push_back(item_row(OP_LIGHT, 0, 1, 1, 0));
      // shared button, evaluate every tick, zero settle and travel, short auto-close
      door_plan.push_back(cfg_row(make_cfg(1, 0, 0, 3, 0)));
      door_plan.push_back(item_row(OP_TICK, 1, 0, 0, 0));
      door_plan.push_back(item_row(OP_DOOR, 1, 1, 1, 0));   // closing while closed: no pulse
      door_plan.push_back(item_row(OP_TICK, 1, 1, 1, 0));   // never operated: counts as timed out
      door_plan.push_back(item_row(OP_DOOR, 0, 0, 0, 0));   // three pulses
      door_plan.push_back(item_row(OP_DOOR, 0, 1, 0, 1));   // reverse while closing
      door_plan.push_back(item_row(OP_TICK, 1, 1, 1, 1));
      door_plan.push_back(item_row(OP_DOOR, 1, 0, 1, 1));   // three pulses from stopped opening
      door_plan.push_back(item_row(OP_DOOR, 1, 1, 0, 1));   // opening while opening: no pulse
      door_plan.push_back(item_row(OP_TICK, 0, 1, 0, 1));
      door_plan.push_back(item_row(OP_TICK, 0, 1, 0, 0));
      door_plan.push_back(item_row(OP_TICK, 0, 1, 0, 1));
      door_plan.push_back(item_row(OP_TICK, 0, 1, 0, 0));   // auto-close pulses on this tick
      door_plan.push_back(item_row(OP_TICK, 0, 0, 1, 0));
      door_plan.push_back(item_row(OP_TICK, 1, 1, 1, 1));   // left a limit without a command
      door_plan.push_back(item_row(OP_DOOR, 0, 0, 0, 1));
      door_plan.push_back(item_row(OP_LIGHT, 1, 1, 0, 1));
      door_plan.push_back(item_row(OP_DOOR, 1, 0, 1, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (door_plan[i]) begin
         if (door_plan[i].is_cfg) program_regs(door_plan[i].cfg);
         else send_and_predict(door_plan[i].stim, door_plan[i].typed, door_plan[i].want);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: c = make_cfg(0, 0, 5, 0, 0);
            1: c = make_cfg(1, 3, 12, 8, 1);
            2: c = make_cfg(1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 16'hFFFF);
            3: c = make_cfg(0, 2, 32'hFFFF_FFFF, 1, 2);
            default: c = make_cfg(1'($urandom_range(1)), $urandom_range(6),
                                  $urandom_range(20), $urandom_range(10),
                                  16'($urandom_range(3)));
         endcase
         program_regs(c);
         if (p < 2) begin
            send_gap_pct = 20;
            rsp_stall_pct = 48;
         end else if (p < 4) begin
            send_gap_pct = 48;
            rsp_stall_pct = 20;
         end else begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         // long response stall while requests keep coming
         if (p == 0) hold_requests++;
         repeat (ITEMS_PER_PHASE) send_and_predict(next_random_item(), 1'b0, '0);
      end

      wait_idle();
      $display("covered %0d request transactions under %0d register settings,",
               items_sent, settings_used);
      $display("  %0d of them requesting button pulses", pulse_items);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("door_opener_state_controller_tb OK");
      end else begin
         $display("door_opener_state_controller_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/dosc_pkg.sv
rtl/dosc_if.sv
rtl/dosc_csr.sv
rtl/dosc_step.sv
rtl/door_opener_state_controller.sv
test/door_opener_state_controller_tb.sv
